// ----- sv/fdep_pkg.sv -----
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared types and constants of the FAT directory entry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fdep_pkg;

    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned NAME_CHARS  = 13;
    localparam int unsigned SHORT_CHARS = 11;

    localparam logic [4:0] ENTRY_LAST_POS = 5'd31;
    localparam logic [4:0] ATTR_POS       = 5'd11;

    localparam logic [7:0] BYTE_FREE      = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_BELOW_A   = 8'h40;
    localparam logic [7:0] CHAR_ABOVE_Z   = 8'h5B;
    localparam logic [7:0] CASE_BIT       = 8'h20;

    // Byte offsets of the character low bytes inside a long-name record.
    localparam logic [4:0] LFN_OFFSET [NAME_CHARS] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16,
        5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

    // Configuration register indexes.
    localparam logic REG_CLUSTER_SECTORS   = 1'b0;
    localparam logic REG_DATA_REGION_START = 1'b1;

    // Decoded entry, handed from the collector to the sector stage.
    typedef struct packed {
        logic [63:0] name_first;
        logic [39:0] name_rest;
        logic        name_is_long;
        logic        is_directory;
        logic [31:0] start_cluster;
        logic [31:0] cluster_offset;
        logic [31:0] size_bytes;
    } fdep_entry_t;

    // Finished result as presented on the output stream.
    typedef struct packed {
        logic [63:0] name_first;
        logic [39:0] name_rest;
        logic        name_is_long;
        logic        is_directory;
        logic [31:0] start_cluster;
        logic [39:0] start_sector;
        logic [31:0] size_bytes;
    } fdep_result_t;

endpackage

`default_nettype wire

// ----- sv/fat_directory_entry_parser.sv -----
// An entry is registered in the collector's entry register, then in the sector stage's result register.
// Throughput: one byte beat per cycle while s_axis_tready is high; at most one result per 32 bytes.
// The decode stage and the sector multiply-add stage each hold one entry, so a waiting
// result does not stop the byte stream until both stages are full.
// Reset (rst_n low, asynchronous) clears position, ignore flag, long name and valid bits;
// sectors per cluster returns to 1 and the data region start to 0.
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// Parses a stream of FAT directory cluster bytes into decoded file entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_entry_parser
    import fdep_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    // Configuration write port.
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_wdata,

    // Byte stream in.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // cluster_end

    // Decoded entries out.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [215:0]      m_axis_tdata,   // [63:0] name_first, [103:64] name_rest,
                                              // [104] is_directory, [136:105] start_cluster,
                                              // [176:137] start_sector, [208:177] size_bytes,
                                              // [215:209] zero
    output logic              m_axis_tuser    // name_is_long
);

    logic [7:0]   cluster_sectors_reg;
    logic [31:0]  data_region_start_reg;

    logic         entry_valid;
    logic         entry_take;
    fdep_entry_t  entry;
    fdep_result_t result;

    // Configuration registers. Writes are to be made only while the parser is idle;
    // the block itself does not enforce this, and the sector stage uses them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_sectors_reg   <= 8'd1;
            data_region_start_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLUSTER_SECTORS:   cluster_sectors_reg   <= cfg_wdata[7:0];
                REG_DATA_REGION_START: data_region_start_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // Stage one: the byte line, entry position and long name tracking. An
    // entry is decoded in the cycle its last byte beat arrives.
    fdep_collector u_collector (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .data_byte   (s_axis_tdata),
        .cluster_end (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .entry_valid (entry_valid),
        .entry_take  (entry_take),
        .entry       (entry)
    );

    // Stage two: the start sector multiply-add and the output register.
    fdep_sector u_sector (
        .clk               (clk),
        .rst_n             (rst_n),
        .entry_valid       (entry_valid),
        .entry             (entry),
        .entry_take        (entry_take),
        .cluster_sectors   (cluster_sectors_reg),
        .data_region_start (data_region_start_reg),
        .result_valid      (m_axis_tvalid),
        .result_ready      (m_axis_tready),
        .result            (result)
    );

    assign m_axis_tdata = {7'b0, result.size_bytes, result.start_sector,
                           result.start_cluster, result.is_directory,
                           result.name_rest, result.name_first};
    assign m_axis_tuser = result.name_is_long;

endmodule

`default_nettype wire

// ----- sv/fdep_collector.sv -----
// ----------------------------------------------------------------------------
// fdep_collector
// Gathers bytes into 32-byte entries, tracks the long name, decodes entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fdep_collector
    import fdep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [7:0]  data_byte,
    input  wire logic        cluster_end,
    output logic             in_ready,
    output logic             entry_valid,
    input  wire logic        entry_take,
    output fdep_entry_t      entry
);

    logic [7:0]  line_reg [ENTRY_BYTES-1];
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic        rest_ignored_reg;
    logic        rest_ignored_next;
    logic        long_pending_reg;
    logic        long_pending_next;
    logic [7:0]  long_chars_reg  [NAME_CHARS];
    logic [7:0]  long_chars_next [NAME_CHARS];
    logic        valid_reg;
    fdep_entry_t entry_reg;
    fdep_entry_t decoded;

    logic [7:0]  ent [ENTRY_BYTES];
    logic [7:0]  name [NAME_CHARS];
    logic        accept;
    logic        fire;
    logic        is_free;
    logic        is_deleted;
    logic        is_lfn;
    logic        produce;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CHAR_SPACE)
            r = 8'h00;
        else if (c > CHAR_BELOW_A && c < CHAR_ABOVE_Z)
            r = c | CASE_BIT;
        return r;
    endfunction

    assign in_ready = !valid_reg || entry_take;
    assign accept   = in_valid && in_ready;

    // The current entry: 31 buffered bytes plus the byte on the input.
    always_comb
    begin
        for (int i = 0; i < ENTRY_BYTES - 1; i++)
            ent[i] = line_reg[i];
        ent[ENTRY_BYTES-1] = data_byte;
    end

    assign fire       = accept && (pos_reg == ENTRY_LAST_POS) && !rest_ignored_reg;
    assign is_free    = (ent[0] == BYTE_FREE);
    assign is_deleted = (ent[0] == BYTE_DELETED);
    assign is_lfn     = (ent[ATTR_POS] == ATTR_LONG_NAME);
    assign produce    = fire && !is_free && !is_deleted && !is_lfn;

    always_comb
    begin
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (long_pending_reg)
                name[i] = long_chars_reg[i];
            else if (i < SHORT_CHARS)
                name[i] = fold_char(ent[i]);
            else
                name[i] = 8'h00;
        end
    end

    always_comb
    begin
        decoded.name_first     = {name[7], name[6], name[5], name[4],
                                  name[3], name[2], name[1], name[0]};
        decoded.name_rest      = {name[12], name[11], name[10], name[9], name[8]};
        decoded.name_is_long   = long_pending_reg;
        decoded.is_directory   = |(ent[ATTR_POS] & ATTR_DIRECTORY);
        decoded.start_cluster  = {ent[21], ent[20], ent[27], ent[26]};
        decoded.cluster_offset = {ent[21], ent[20], ent[27], ent[26]} - 32'd2;
        decoded.size_bytes     = {ent[31], ent[30], ent[29], ent[28]};
    end

    always_comb
    begin
        pos_next          = pos_reg;
        rest_ignored_next = rest_ignored_reg;
        long_pending_next = long_pending_reg;
        for (int i = 0; i < NAME_CHARS; i++)
            long_chars_next[i] = long_chars_reg[i];

        if (accept)
            pos_next = pos_reg + 5'd1;

        if (fire && is_free)
            rest_ignored_next = 1'b1;

        if (fire && !is_free && !is_deleted && is_lfn)
        begin
            long_pending_next = 1'b1;
            for (int i = 0; i < NAME_CHARS; i++)
                long_chars_next[i] = ent[LFN_OFFSET[i]];
        end
        else if (produce)
        begin
            long_pending_next = 1'b0;
            for (int i = 0; i < NAME_CHARS; i++)
                long_chars_next[i] = 8'h00;
        end

        // A cluster end drops any partial entry and all pending name state.
        if (accept && cluster_end)
        begin
            pos_next          = '0;
            rest_ignored_next = 1'b0;
            long_pending_next = 1'b0;
            for (int i = 0; i < NAME_CHARS; i++)
                long_chars_next[i] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            rest_ignored_reg <= 1'b0;
            long_pending_reg <= 1'b0;
            valid_reg        <= 1'b0;
            for (int i = 0; i < NAME_CHARS; i++)
                long_chars_reg[i] <= 8'h00;
        end
        else
        begin
            pos_reg          <= pos_next;
            rest_ignored_reg <= rest_ignored_next;
            long_pending_reg <= long_pending_next;
            for (int i = 0; i < NAME_CHARS; i++)
                long_chars_reg[i] <= long_chars_next[i];
            if (in_ready)
                valid_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < ENTRY_BYTES - 2; i++)
                line_reg[i] <= line_reg[i+1];
            line_reg[ENTRY_BYTES-2] <= data_byte;
        end
        if (produce)
            entry_reg <= decoded;
    end

    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

`ifndef SYNTHESIS
    a_cluster_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cluster_end) |=> (pos_reg == '0))
        else $error("position not cleared after cluster end");

    a_ignore_starts_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rest_ignored_reg) |-> (pos_reg == '0))
        else $error("rest of cluster ignored away from an entry boundary");

    a_idle_name_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !long_pending_reg |-> ({long_chars_reg[0], long_chars_reg[1], long_chars_reg[2],
                                long_chars_reg[3], long_chars_reg[4], long_chars_reg[5],
                                long_chars_reg[6], long_chars_reg[7], long_chars_reg[8],
                                long_chars_reg[9], long_chars_reg[10], long_chars_reg[11],
                                long_chars_reg[12]} == '0))
        else $error("long name characters left without a pending long name");
`endif

endmodule

`default_nettype wire

// ----- sv/fdep_sector.sv -----
// ----------------------------------------------------------------------------
// fdep_sector
// Computes the start sector and holds the result register of the output.
// ----------------------------------------------------------------------------
`default_nettype none

module fdep_sector
    import fdep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        entry_valid,
    input  wire fdep_entry_t entry,
    output logic             entry_take,
    input  wire logic [7:0]  cluster_sectors,
    input  wire logic [31:0] data_region_start,
    output logic             result_valid,
    input  wire logic        result_ready,
    output fdep_result_t     result
);

    logic         valid_reg;
    fdep_result_t result_reg;
    logic         out_free;
    logic [39:0]  sector_next;

    assign out_free   = !valid_reg || result_ready;
    assign entry_take = entry_valid && out_free;

    // 32x8 product plus the data region base fits in 40 bits.
    assign sector_next = ({8'h00, entry.cluster_offset} * {32'h0000_0000, cluster_sectors})
                       + {8'h00, data_region_start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_free)
            valid_reg <= entry_valid;
    end

    always_ff @(posedge clk)
    begin
        if (entry_take)
        begin
            result_reg.name_first    <= entry.name_first;
            result_reg.name_rest     <= entry.name_rest;
            result_reg.name_is_long  <= entry.name_is_long;
            result_reg.is_directory  <= entry.is_directory;
            result_reg.start_cluster <= entry.start_cluster;
            result_reg.start_sector  <= sector_next;
            result_reg.size_bytes    <= entry.size_bytes;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
